/* hw/rtl/bqsa_pkg.sv */
// Shared types and constants for the bounded queue server admission block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bqsa_pkg;

  localparam int ARRIVAL_W        = 32;
  localparam int DURATION_W       = 32;
  localparam int TIME_W           = 48;
  localparam int CAP_W            = 4;
  localparam int MAX_HELD_DEFAULT = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET = 4'd15;
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                 exec;     // the cells update in this cycle
    logic                 admit;    // the job is admitted: shift the chain by one
    logic [ARRIVAL_W-1:0] arrival;  // arrival time used for retirement
  } bqsa_cell_ctrl_t;

endpackage : bqsa_pkg

`default_nettype wire

/* hw/rtl/bqsa_if.sv */
// Valid/ready channel interfaces for job arrivals and admission results.
// Depends on bqsa_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bqsa_job_if
  import bqsa_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [ARRIVAL_W-1:0]  arrival_time;
  logic [DURATION_W-1:0] job_duration;

  modport source (output valid, output arrival_time, output job_duration, input ready);
  modport sink   (input valid, input arrival_time, input job_duration, output ready);
endinterface : bqsa_job_if

interface bqsa_result_if
  import bqsa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              dropped;
  logic [TIME_W-1:0] completion_time;

  modport source (output valid, output dropped, output completion_time, input ready);
  modport sink   (input valid, input dropped, input completion_time, output ready);
endinterface : bqsa_result_if

`default_nettype wire

/* hw/rtl/bounded_queue_server_admission.sv */
// Top level of the single-server queue with tail drop: sequencer, adder and cell chain.
// Depends on bqsa_pkg, bqsa_if.sv and bqsa_cell.
//
// Each job transaction runs through the states IDLE and EXEC: IDLE captures the arrival and
// forms the start time as the later of the server free time and the arrival; EXEC lets every
// cell of the chain retire its job in parallel, decides admission and adds the duration. A
// new job is accepted in the cycle after that, so the block takes no new job before the last
// one is decided, and a result that is not taken holds the decision cycle. Admitted finish
// times never decrease, so the chain keeps jobs newest first at cell 0, and the held jobs
// always form a solid run from cell 0. An admission shifts the chain by one place and the
// drop decision reads a single valid bit at the cell given by the waiting capacity. The
// capacity register resets to 15; the user writes it through cfg_we and cfg_wdata only while
// the block is idle, which the block does not enforce. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module bounded_queue_server_admission
  import bqsa_pkg::*;
#(
  parameter int MAX_HELD = MAX_HELD_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  bqsa_job_if.sink              job,
  bqsa_result_if.source         result,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_HELD);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t               state;
  logic [CAP_W-1:0]     cap;
  logic [TIME_W-1:0]    server_free;
  logic [ARRIVAL_W-1:0] arrival;
  logic [DURATION_W-1:0] duration;
  logic [TIME_W-1:0]    start;
  logic                 out_valid;
  logic                 out_dropped;
  logic [TIME_W-1:0]    out_finish;

  logic                 job_take;
  logic                 exec_go;
  logic [TIME_W:0]      sum;
  logic [TIME_W-1:0]    new_finish;
  logic [TIME_W-1:0]    arrival_ext;
  logic [IDX_W-1:0]     limit_idx;
  logic                 drop;
  bqsa_cell_ctrl_t      ctrl;

  logic [MAX_HELD-1:0]  held_vec;
  logic [MAX_HELD-1:0]  live_vec;
  logic [TIME_W-1:0]    cell_finish [MAX_HELD];

  assign job.ready   = (state == IDLE);
  assign job_take    = job.valid && job.ready;
  assign arrival_ext = {{(TIME_W-ARRIVAL_W){1'b0}}, job.arrival_time};

  // The decision cycle runs only once the output register is free or being emptied.
  assign exec_go = (state == EXEC) && (!out_valid || result.ready);

  // Saturating add: the start time is below 2^48 and the duration below 2^32.
  assign sum        = {1'b0, start} + {{(TIME_W-DURATION_W+1){1'b0}}, duration};
  assign new_finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  // The line is full when the cell at the capacity index is still live after retirement;
  // a capacity beyond the chain collapses onto the last cell, which also covers a full chain.
  always_comb begin
    if (int'(cap) >= MAX_HELD - 1) begin
      limit_idx = IDX_W'(MAX_HELD - 1);
    end else begin
      limit_idx = IDX_W'(cap);
    end
  end

  assign drop = live_vec[limit_idx];

  assign ctrl.exec    = exec_go;
  assign ctrl.admit   = !drop;
  assign ctrl.arrival = arrival;

  // Cell 0 takes the new job; every other cell takes what its neighbor held.
  for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
    if (i == 0) begin : g_head
      bqsa_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .prev_live   (1'b1),
        .prev_finish (new_finish),
        .held        (held_vec[i]),
        .live        (live_vec[i]),
        .finish      (cell_finish[i])
      );
    end else begin : g_body
      bqsa_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .prev_live   (live_vec[i-1]),
        .prev_finish (cell_finish[i-1]),
        .held        (held_vec[i]),
        .live        (live_vec[i]),
        .finish      (cell_finish[i])
      );
    end
  end

  // Sequencer, server free time and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      cap         <= CAP_RESET;
      server_free <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      // A new decision refills the output register even while the old result leaves.
      if (exec_go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (job_take) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (exec_go) begin
            state <= IDLE;
            if (!drop) begin
              server_free <= new_finish;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (job_take) begin
      arrival  <= job.arrival_time;
      duration <= job.job_duration;
      start    <= (server_free > arrival_ext) ? server_free : arrival_ext;
    end
    if (exec_go) begin
      out_dropped <= drop;
      out_finish  <= drop ? '0 : new_finish;
    end
  end

  assign result.valid           = out_valid;
  assign result.dropped         = out_dropped;
  assign result.completion_time = out_finish;

  // Held jobs always occupy a solid run of cells starting at cell 0.
  a_held_solid: assert property (@(posedge clk) disable iff (rst)
    (held_vec & (held_vec + 1'b1)) == '0)
    else $error("held cells are not a solid run from cell 0");

  // A decision always leaves a result in the output register.
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> out_valid && (state == IDLE))
    else $error("decision cycle did not produce a result");

  // A dropped job changes the chain only by retirement.
  a_drop_keeps: assert property (@(posedge clk) disable iff (rst)
    exec_go && drop |=> held_vec == $past(live_vec))
    else $error("dropped job altered the held cells");

  // An admitted job never moves the server free time backward.
  a_free_mono: assert property (@(posedge clk) disable iff (rst)
    exec_go && !drop |=> server_free >= $past(server_free))
    else $error("server free time decreased");

endmodule : bounded_queue_server_admission

`default_nettype wire

/* hw/rtl/bqsa_cell.sv */
// One cell of the held-job chain: a finish time and its valid bit.
// Depends on bqsa_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module bqsa_cell
  import bqsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bqsa_cell_ctrl_t   ctrl,
  input  wire logic              prev_live,
  input  wire logic [TIME_W-1:0] prev_finish,
  output logic                   held,
  output logic                   live,
  output logic [TIME_W-1:0]      finish
);

  // A held job retires once its finish time is at or before the arrival.
  assign live = held && (finish > {{(TIME_W-ARRIVAL_W){1'b0}}, ctrl.arrival});

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (ctrl.exec) begin
      held <= ctrl.admit ? prev_live : live;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && ctrl.admit) begin
      finish <= prev_finish;
    end
  end

endmodule : bqsa_cell

`default_nettype wire
